[design/lps_pkg.sv]
// Shared types and constants for the line pixel stepper.
// No dependencies; every other design file imports this package.
package lps_pkg;

  // Fixed field widths
  localparam int COORD_BITS_DEF  = 12;
  localparam int CFG_WIDTH_BITS  = 12;
  localparam int CFG_PIXELS_BITS = 23;
  localparam int CFG_INDEX_BITS  = 1;
  localparam int ADDR_BITS       = 22;
  localparam int COLOR_BITS      = 24;

  // Register reset values
  localparam logic [CFG_WIDTH_BITS-1:0]  CANVAS_WIDTH_RST  = CFG_WIDTH_BITS'(320);
  localparam logic [CFG_PIXELS_BITS-1:0] CANVAS_PIXELS_RST = CFG_PIXELS_BITS'(76800);

  // Input beat kind carried in tuser
  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Configuration register index
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_CANVAS_WIDTH  = 1'b0,
    CFG_CANVAS_PIXELS = 1'b1
  } cfg_reg_e;

  // Status of the stepper toward the pixel pipeline
  typedef struct packed {
    logic active;  // a line is being drawn
    logic last;    // current pixel is the end point
  } step_ctl_t;

endpackage

[design/line_pixel_stepper_top.sv]
// Top level of the line pixel stepper: stream ports, config registers and
// the two-stage address pipeline. Depends on lps_pkg and lps_stepper.
//
//  channel  direction  beat content
//  s_axis   in         tuser op; tdata start_x, start_y, end_x, end_y, color
//  m_axis   out        tuser write_enable; tlast last_pixel; tdata x, y, addr, color
//  cfg      in         cfg_index_i register, cfg_data_i value
//
// One beat per cycle in both directions unless the output stalls. A tick beat's
// pixel passes through both stages in turn: one holds coordinates and the row
// product y*width, the next adds x, range checks and holds the result. Loads and
// ticks while idle give no output. Reset idles the stepper and sets width 320,
// pixels 76800. A stalled output freezes the whole pipe and drops s_axis_tready.
module line_pixel_stepper_top
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // input stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [0] op
  input  logic [0:0] s_axis_tuser,
  // start_x, start_y, end_x, end_y, line_color, zero fill
  input  logic [((4*COORD_BITS+COLOR_BITS+7)/8)*8-1:0] s_axis_tdata,
  // output stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [0] write_enable
  output logic [0:0] m_axis_tuser,
  output logic m_axis_tlast,
  // pixel_x, pixel_y, pixel_address, pixel_color, zero fill
  output logic [((2*COORD_BITS+ADDR_BITS+COLOR_BITS+7)/8)*8-1:0] m_axis_tdata,
  // configuration writes
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_PIXELS_BITS-1:0] cfg_data_i
);

  localparam int OUT_W  = ((2*COORD_BITS+ADDR_BITS+COLOR_BITS+7)/8)*8;
  localparam int OUT_P  = 2*COORD_BITS+ADDR_BITS+COLOR_BITS;
  localparam int PROD_W = COORD_BITS + CFG_WIDTH_BITS;
  localparam int SUM_W  = PROD_W + 1;
  localparam int CMP_W  = (SUM_W > CFG_PIXELS_BITS + 1) ? SUM_W : CFG_PIXELS_BITS + 1;
  localparam logic [CMP_W-1:0] ADDR_LIMIT = CMP_W'(64'd1 << ADDR_BITS);

  // Configuration registers
  logic [CFG_WIDTH_BITS-1:0]  canvas_width_q;
  logic [CFG_PIXELS_BITS-1:0] canvas_pixels_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      canvas_width_q  <= CANVAS_WIDTH_RST;
      canvas_pixels_q <= CANVAS_PIXELS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_CANVAS_WIDTH:  canvas_width_q  <= cfg_data_i[CFG_WIDTH_BITS-1:0];
        CFG_CANVAS_PIXELS: canvas_pixels_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: whole pipe advances when the output slot is free or taken
  logic adv, in_fire, load_fire, tick_fire;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_fire       = s_axis_tvalid && adv;
  assign load_fire     = in_fire && (op_e'(s_axis_tuser) == OP_LOAD);
  assign tick_fire     = in_fire && (op_e'(s_axis_tuser) == OP_TICK);

  // Stepper
  logic signed [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_BITS-1:0]        pix_color;
  step_ctl_t                    ctl;

  lps_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load_fire),
    .tick_i   (tick_fire),
    .start_x_i(s_axis_tdata[COORD_BITS-1:0]),
    .start_y_i(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i  (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i  (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .color_i  (s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS]),
    .pix_x_o  (pix_x),
    .pix_y_o  (pix_y),
    .color_o  (pix_color),
    .ctl_o    (ctl)
  );

  // Stage 1: coordinates and row product
  logic                         s1_valid_q, s1_valid_d;
  logic signed [COORD_BITS-1:0] s1_x_q, s1_y_q;
  logic [PROD_W-1:0]            s1_prod_q;
  logic [COLOR_BITS-1:0]        s1_color_q;
  logic                         s1_last_q;
  logic [PROD_W-1:0]            row_prod;

  assign s1_valid_d = tick_fire && ctl.active;
  assign row_prod   = PROD_W'($unsigned(pix_y)) * PROD_W'(canvas_width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q     <= pix_x;
      s1_y_q     <= pix_y;
      s1_prod_q  <= row_prod;
      s1_color_q <= pix_color;
      s1_last_q  <= ctl.last;
    end
  end

  // Stage 2: add x, range check, output register
  logic [CMP_W-1:0]      idx;
  logic                  in_buf;
  logic                  out_valid_q;
  logic                  out_we_q, out_we_d;
  logic [ADDR_BITS-1:0]  out_addr_q, out_addr_d;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;
  logic [COLOR_BITS-1:0] out_color_q;
  logic                  out_last_q;

  always_comb begin
    idx        = CMP_W'(SUM_W'(s1_prod_q) + SUM_W'($unsigned(s1_x_q)));
    in_buf     = (idx < CMP_W'(canvas_pixels_q)) && (idx < ADDR_LIMIT);
    out_we_d   = !s1_x_q[COORD_BITS-1] && !s1_y_q[COORD_BITS-1] && in_buf;
    out_addr_d = out_we_d ? idx[ADDR_BITS-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_we_q    <= out_we_d;
      out_addr_q  <= out_addr_d;
      out_x_q     <= s1_x_q;
      out_y_q     <= s1_y_q;
      out_color_q <= s1_color_q;
      out_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_we_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = OUT_W'({out_color_q, out_addr_q, out_y_q, out_x_q});

`ifndef SYNTHESIS
  a_we_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_we_q) |-> (!out_x_q[COORD_BITS-1] && !out_y_q[COORD_BITS-1]))
    else $error("write enabled for a negative coordinate");

  a_skip_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_we_q) |-> (out_addr_q == '0))
    else $error("skipped pixel carries a nonzero address");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !adv) |=> (s1_valid_q && $stable(s1_prod_q)))
    else $error("stage 1 lost its pixel during a stall");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata >> OUT_P) == '0)
    else $error("output fill bits not zero");
`endif

endmodule

[design/lps_stepper.sv]
// Bresenham state: line setup on load and one error-term step per tick
// while active; a tick at the end point ends the line. Depends on lps_pkg.
module lps_stepper
  import lps_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  logic                         tick_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic [COLOR_BITS-1:0]        color_i,
  output logic signed [COORD_BITS-1:0] pix_x_o,
  output logic signed [COORD_BITS-1:0] pix_y_o,
  output logic [COLOR_BITS-1:0]        color_o,
  output step_ctl_t                    ctl_o
);

  localparam int DW = COORD_BITS + 1;  // coordinate difference
  localparam int TW = COORD_BITS + 2;  // twice a delta
  localparam int EW = COORD_BITS + 3;  // decision term

  logic                         active_q, active_d;
  logic                         steep_q, steep_d;
  logic signed [COORD_BITS-1:0] major_pos_q, major_pos_d;
  logic signed [COORD_BITS-1:0] minor_pos_q, minor_pos_d;
  logic signed [COORD_BITS-1:0] major_end_q, major_end_d;
  logic                         step_neg_q, step_neg_d;
  logic signed [EW-1:0]         decision_q, decision_d;
  logic [TW-1:0]                twice_maj_q, twice_maj_d;
  logic [TW-1:0]                twice_min_q, twice_min_d;
  logic [COLOR_BITS-1:0]        color_q, color_d;

  // Line setup
  logic signed [DW-1:0] dx, dy, d_maj, d_min;
  logic [DW-1:0]        adx, ady, abs_maj, abs_min;
  logic signed [COORD_BITS-1:0] a0, a1, b0, b1;
  logic                 steep_ld, swap;
  logic                 last;
  logic                 dec_pos;
  logic signed [EW-1:0] dec_step;

  always_comb begin
    dx       = DW'(end_x_i) - DW'(start_x_i);
    dy       = DW'(end_y_i) - DW'(start_y_i);
    adx      = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady      = dy[DW-1] ? DW'(-dy) : DW'(dy);
    steep_ld = !(ady < adx);
    d_maj    = steep_ld ? dy : dx;
    d_min    = steep_ld ? dx : dy;
    abs_maj  = steep_ld ? ady : adx;
    abs_min  = steep_ld ? adx : ady;
    a0       = steep_ld ? start_y_i : start_x_i;
    a1       = steep_ld ? end_y_i : end_x_i;
    b0       = steep_ld ? start_x_i : start_y_i;
    b1       = steep_ld ? end_x_i : end_y_i;
    // endpoints are swapped when the major delta is negative
    swap     = d_maj[DW-1];
  end

  // Pixel at the current position
  assign last    = major_pos_q >= major_end_q;
  assign pix_x_o = steep_q ? minor_pos_q : major_pos_q;
  assign pix_y_o = steep_q ? major_pos_q : minor_pos_q;
  assign color_o = color_q;
  assign ctl_o   = '{active: active_q, last: last};

  // Next state: load, or one step per tick while active; a tick at the last pixel ends the line
  always_comb begin
    active_d    = active_q;
    steep_d     = steep_q;
    major_pos_d = major_pos_q;
    minor_pos_d = minor_pos_q;
    major_end_d = major_end_q;
    step_neg_d  = step_neg_q;
    decision_d  = decision_q;
    twice_maj_d = twice_maj_q;
    twice_min_d = twice_min_q;
    color_d     = color_q;
    dec_pos     = decision_q > 0;
    dec_step    = dec_pos ? $signed(EW'(twice_maj_q)) : '0;
    if (load_i) begin
      active_d    = 1'b1;
      steep_d     = steep_ld;
      major_pos_d = swap ? a1 : a0;
      minor_pos_d = swap ? b1 : b0;
      major_end_d = swap ? a0 : a1;
      step_neg_d  = swap ? (!d_min[DW-1] && (d_min != '0)) : d_min[DW-1];
      twice_maj_d = {abs_maj, 1'b0};
      twice_min_d = {abs_min, 1'b0};
      decision_d  = $signed(EW'({abs_min, 1'b0})) - $signed(EW'(abs_maj));
      color_d     = color_i;
    end else if (tick_i && active_q) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        if (dec_pos) begin
          minor_pos_d = step_neg_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
        end
        decision_d  = decision_q + $signed(EW'(twice_min_q)) - dec_step;
        major_pos_d = major_pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  // Line payload, meaningful only while active
  always_ff @(posedge clk_i) begin
    steep_q     <= steep_d;
    major_pos_q <= major_pos_d;
    minor_pos_q <= minor_pos_d;
    major_end_q <= major_end_d;
    step_neg_q  <= step_neg_d;
    decision_q  <= decision_d;
    twice_maj_q <= twice_maj_d;
    twice_min_q <= twice_min_d;
    color_q     <= color_d;
  end

`ifndef SYNTHESIS
  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> active_q)
    else $error("load did not start a line");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_i && !load_i && active_q && last) |=> !active_q)
    else $error("line kept running after its last pixel");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (major_pos_q <= major_end_q))
    else $error("major position passed the end point");
`endif

endmodule
